// ===== rtl/core/complex_to_polar_select_assert.svh =====
`ifndef COMPLEX_TO_POLAR_SELECT_ASSERT_SVH
`define COMPLEX_TO_POLAR_SELECT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CPS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cps implication failed");

// implication after a fixed number of cycles
`define CPS_ASSERT_DELAY(label, ante, cons, n) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("cps delayed implication failed");

`endif

// ===== rtl/core/cps_pkg.sv =====
package cps_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int XW           = 43;
    localparam int ZW           = 34;
    localparam int PW           = 58;
    localparam int LATENCY      = CORDIC_STEPS + 4;

    localparam logic [2:0] MODE_MAG   = 3'd0;
    localparam logic [2:0] MODE_PHASE = 3'd1;
    localparam logic [2:0] MODE_REAL  = 3'd2;
    localparam logic [2:0] MODE_IMAG  = 3'd3;
    localparam logic [2:0] MODE_POLAR = 3'd4;

    localparam logic signed [ZW-1:0] DEG90_Z   = 34'sd1509949440;
    localparam logic signed [34:0]   PH180_Q16 = 35'sd11796480;
    localparam logic [15:0]          INVK_HI   = 16'h9B74;
    localparam logic [15:0]          INVK_LO   = 16'hEDA8;

    typedef logic signed [XW-1:0] vec_t;
    typedef logic signed [ZW-1:0] ang_t;

    typedef struct packed {
        logic [31:0] abscissa;
        logic [31:0] part;
        logic        last;
        logic [2:0]  mode;
        logic        zero;
    } side_t;

    typedef struct packed {
        vec_t  x;
        vec_t  y;
        ang_t  z;
        side_t side;
    } rot_t;

    // atan(2^-k) in degrees, scaled by 2^24
    function automatic ang_t atan_step(input int unsigned k);
        unique case (k)
            0:       return 34'sd754974720;
            1:       return 34'sd445687602;
            2:       return 34'sd235489088;
            3:       return 34'sd119537938;
            4:       return 34'sd60000934;
            5:       return 34'sd30029717;
            6:       return 34'sd15018523;
            7:       return 34'sd7509720;
            8:       return 34'sd3754917;
            9:       return 34'sd1877466;
            10:      return 34'sd938734;
            11:      return 34'sd469367;
            12:      return 34'sd234684;
            13:      return 34'sd117342;
            14:      return 34'sd58671;
            15:      return 34'sd29335;
            16:      return 34'sd14668;
            17:      return 34'sd7334;
            18:      return 34'sd3667;
            19:      return 34'sd1833;
            20:      return 34'sd917;
            21:      return 34'sd458;
            22:      return 34'sd229;
            23:      return 34'sd115;
            24:      return 34'sd57;
            25:      return 34'sd29;
            26:      return 34'sd14;
            27:      return 34'sd7;
            28:      return 34'sd4;
            29:      return 34'sd2;
            30:      return 34'sd1;
            default: return 34'sd0;
        endcase
    endfunction

endpackage

// ===== rtl/core/complex_to_polar_select.sv =====
// channel    | handshake            | payload
// -----------+----------------------+------------------------------------------------
// sample in  | start, busy          | abscissa_in, real_part, imag_part, last_in
// config     | cfg_valid, cfg_ready | cfg_data (quantity_mode)
// result out | done strobe          | abscissa_out, ordinate_out, last_out
//
// one request per cycle
// the pipeline has one pre-rotation stage, one stage per cordic
// micro-rotation, then multiply, round/clamp and output select stages
// busy is always low and cfg_ready always high; the receiver cannot stall
// rst_n clears the stage valid bits, done and quantity_mode (to real)
module complex_to_polar_select
    import cps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] abscissa_in,
    input  logic signed [31:0] real_part,
    input  logic signed [31:0] imag_part,
    input  logic               last_in,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_data,
    output logic               done,
    output logic signed [31:0] abscissa_out,
    output logic signed [32:0] ordinate_out,
    output logic               last_out
);

    logic [2:0] mode_reg;

    rot_t                  rot_reg [0:CORDIC_STEPS];
    logic [CORDIC_STEPS:0] rvld_reg;
    rot_t                  pre_next;

    logic [PW-1:0]      prod_hi_reg, prod_lo_reg;
    ang_t               mz_reg;
    side_t              mside_reg;
    logic               mvld_reg;
    logic [PW-1:0]      prod_hi_next, prod_lo_next;
    logic [XW-2:0]      ux;

    logic [32:0]        mag_reg, mag_next;
    logic signed [31:0] ph_reg, ph_next;
    side_t              fside_reg;
    logic               fvld_reg;
    logic [PW:0]        mag_sum;
    logic signed [34:0] z_round, ph_full;

    logic               done_reg;
    logic signed [31:0] abscissa_reg, abscissa_next;
    logic signed [32:0] ordinate_reg, ordinate_next;
    logic               last_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_REAL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= cfg_data;
        end
    end

    // quadrant pre-rotation on the inputs scaled by 2^8
    always_comb
    begin
        vec_t ext_re, ext_im;
        ext_re = vec_t'({{3{real_part[31]}}, real_part, 8'b0});
        ext_im = vec_t'({{3{imag_part[31]}}, imag_part, 8'b0});
        pre_next.x = ext_re;
        pre_next.y = ext_im;
        pre_next.z = '0;
        if (real_part[31])
        begin
            if (!imag_part[31])
            begin
                pre_next.x = ext_im;
                pre_next.y = -ext_re;
                pre_next.z = DEG90_Z;
            end
            else
            begin
                pre_next.x = -ext_im;
                pre_next.y = ext_re;
                pre_next.z = -DEG90_Z;
            end
        end
        pre_next.side.abscissa = abscissa_in;
        pre_next.side.part     = (mode_reg == MODE_IMAG) ? imag_part : real_part;
        pre_next.side.last     = last_in;
        pre_next.side.mode     = mode_reg;
        pre_next.side.zero     = (real_part == '0) && (imag_part == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvld_reg[0] <= 1'b0;
        end
        else
        begin
            rvld_reg[0] <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        rot_reg[0] <= pre_next;
    end

    // one micro-rotation per stage
    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_rot
        rot_t rot_next;

        always_comb
        begin
            vec_t dx, dy;
            dx = $signed(rot_reg[k].y) >>> k;
            dy = $signed(rot_reg[k].x) >>> k;
            rot_next = rot_reg[k];
            if (rot_reg[k].y[XW-1])
            begin
                rot_next.x = $signed(rot_reg[k].x) - dx;
                rot_next.y = $signed(rot_reg[k].y) + dy;
                rot_next.z = $signed(rot_reg[k].z) - atan_step(k);
            end
            else
            begin
                rot_next.x = $signed(rot_reg[k].x) + dx;
                rot_next.y = $signed(rot_reg[k].y) - dy;
                rot_next.z = $signed(rot_reg[k].z) + atan_step(k);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rvld_reg[k+1] <= 1'b0;
            end
            else
            begin
                rvld_reg[k+1] <= rvld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rot_reg[k+1] <= rot_next;
        end
    end

    // gain correction, split into two partial products by the 16-bit halves of the constant
    always_comb
    begin
        ux = rot_reg[CORDIC_STEPS].x[XW-1] ? '0 : rot_reg[CORDIC_STEPS].x[XW-2:0];
        prod_hi_next = PW'(ux) * PW'(INVK_HI);
        prod_lo_next = PW'(ux) * PW'(INVK_LO);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mvld_reg <= 1'b0;
            fvld_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            mvld_reg <= rvld_reg[CORDIC_STEPS];
            fvld_reg <= mvld_reg;
            done_reg <= fvld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_hi_reg <= prod_hi_next;
        prod_lo_reg <= prod_lo_next;
        mz_reg      <= rot_reg[CORDIC_STEPS].z;
        mside_reg   <= rot_reg[CORDIC_STEPS].side;
    end

    // round magnitude half up, round phase to q16.16 and clamp to +-180; a zero sample gives zero for both
    always_comb
    begin
        mag_sum  = (PW+1)'(prod_hi_reg) + (PW+1)'(prod_lo_reg >> 16) + (PW+1)'(1 << 23);
        z_round  = 35'(mz_reg) + 35'sd128;
        ph_full  = z_round >>> 8;
        if (ph_full > PH180_Q16)
        begin
            ph_full = PH180_Q16;
        end
        else if (ph_full < -PH180_Q16)
        begin
            ph_full = -PH180_Q16;
        end
        mag_next = mag_sum[56:24];
        ph_next  = ph_full[31:0];
        if (mside_reg.zero)
        begin
            mag_next = '0;
            ph_next  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        ph_reg    <= ph_next;
        fside_reg <= mside_reg;
    end

    always_comb
    begin
        abscissa_next = fside_reg.abscissa;
        unique case (fside_reg.mode)
            MODE_MAG:   ordinate_next = mag_reg;
            MODE_PHASE: ordinate_next = {ph_reg[31], ph_reg};
            MODE_POLAR:
            begin
                abscissa_next = ph_reg;
                ordinate_next = mag_reg;
            end
            default:    ordinate_next = {fside_reg.part[31], fside_reg.part};
        endcase
    end

    always_ff @(posedge clk)
    begin
        abscissa_reg <= abscissa_next;
        ordinate_reg <= ordinate_next;
        last_reg     <= fside_reg.last;
    end

    assign done         = done_reg;
    assign abscissa_out = abscissa_reg;
    assign ordinate_out = ordinate_reg;
    assign last_out     = last_reg;

endmodule

// ===== rtl/core/cps_checker.sv =====
`include "complex_to_polar_select_assert.svh"

module cps_checker
    import cps_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic last_in,
    input logic done,
    input logic last_out
);

    // every request comes back as a done
    `CPS_ASSERT_DELAY(a_req_gives_result, start && !busy, done, LATENCY)

    // no result without a request at the matching time
    `CPS_ASSERT_IMPLY(a_no_spurious_result, done, $past(start && !busy, LATENCY))

    // the last marker travels with its request
    `CPS_ASSERT_IMPLY(a_last_follows, done, last_out == $past(last_in, LATENCY))

endmodule

bind complex_to_polar_select cps_checker u_cps_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import cps_pkg::*;

    localparam logic [2:0] MODE_SPARE5 = 3'd5;
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned CHUNK_ITEMS = 115;
    localparam longint PHASE_LIMIT = 64'sd11796480;

    typedef struct packed {
        logic [31:0] abscissa;
        logic [32:0] ordinate;
        logic        last;
    } polar_result_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] abscissa_in;
    logic signed [31:0] real_part;
    logic signed [31:0] imag_part;
    logic               last_in;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_data;
    logic               done;
    logic signed [31:0] abscissa_out;
    logic signed [32:0] ordinate_out;
    logic               last_out;

    logic [2:0]    model_mode;
    polar_result_t pending_results[$];
    int unsigned   error_count;
    int unsigned   cycle_count;
    int unsigned   sender_idle_pct;

    // atan(2^-k) in degrees, scaled by 2^24
    longint angle_table [24] = '{
        754974720, 445687602, 235489088, 119537938,
        60000934, 30029717, 15018523, 7509720,
        3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335,
        14668, 7334, 3667, 1833,
        917, 458, 229, 115
    };

    complex_to_polar_select uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .abscissa_in  (abscissa_in),
        .real_part    (real_part),
        .imag_part    (imag_part),
        .last_in      (last_in),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .done         (done),
        .abscissa_out (abscissa_out),
        .ordinate_out (ordinate_out),
        .last_out     (last_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // vectoring cordic on the sample scaled by 2^8
    task automatic polar_of(input logic signed [31:0] re, input logic signed [31:0] im,
                            output longint unsigned mag, output longint ph);
        longint x;
        longint y;
        longint z;
        longint t;
        longint dx;
        longint dy;
        longint unsigned ux;
        mag = 0;
        ph  = 0;
        if (re != 0 || im != 0)
        begin
            x = longint'(re) * 256;
            y = longint'(im) * 256;
            z = 0;
            if (x < 0)
            begin
                t = x;
                if (y >= 0)
                begin
                    x = y;
                    y = -t;
                    z = longint'(DEG90_Z);
                end
                else
                begin
                    x = -y;
                    y = t;
                    z = -longint'(DEG90_Z);
                end
            end
            for (int k = 0; k < CORDIC_STEPS; k++)
            begin
                dx = y >>> k;
                dy = x >>> k;
                if (y < 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - angle_table[k];
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + angle_table[k];
                end
            end
            ux  = (x < 0) ? 64'd0 : longint'(x);
            mag = (ux * 64'h9B74 + ((ux * 64'hEDA8) >> 16) + 64'h80_0000) >> 24;
            t   = (z + 128) >>> 8;
            if (t > PHASE_LIMIT)
                t = PHASE_LIMIT;
            if (t < -PHASE_LIMIT)
                t = -PHASE_LIMIT;
            ph = t;
        end
    endtask

    task automatic predict_polar(input logic signed [31:0] a, input logic signed [31:0] re,
                                 input logic signed [31:0] im, input logic last);
        polar_result_t     r;
        longint unsigned   mag;
        longint            ph;
        longint            yo;
        mag = 0;
        ph  = 0;
        if (model_mode == MODE_MAG || model_mode == MODE_PHASE || model_mode == MODE_POLAR)
            polar_of(re, im, mag, ph);
        r.abscissa = a;
        r.last     = last;
        case (model_mode)
            MODE_MAG:   yo = longint'(mag);
            MODE_PHASE: yo = ph;
            MODE_IMAG:  yo = longint'(im);
            MODE_POLAR:
            begin
                r.abscissa = ph[31:0];
                yo         = longint'(mag);
            end
            default:    yo = longint'(re);
        endcase
        r.ordinate = yo[32:0];
        pending_results.push_back(r);
    endtask

    task automatic send_sample(input logic [31:0] a, input logic [31:0] re,
                               input logic [31:0] im, input logic last);
        @(negedge clk);
        start       <= 1'b1;
        abscissa_in <= a;
        real_part   <= re;
        imag_part   <= im;
        last_in     <= last;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predict_polar(a, re, im, last);
    endtask

    task automatic sender_gap();
        int unsigned n;
        n = 0;
        while ($urandom_range(99) < sender_idle_pct && n < 200)
            n++;
        if (n > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic write_mode(input logic [2:0] m);
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        model_mode = m;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] random_part();
        logic [31:0] v;
        case ($urandom_range(11))
            0:       v = 32'h0000_0000;
            1:       v = 32'h8000_0000;
            2:       v = 32'h7FFF_FFFF;
            3:       v = 32'($urandom_range(511)) - 32'd256;
            4:       v = 32'($urandom_range(1 << 20)) - 32'h8_0000;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic test_default_mode();
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    endtask

    task automatic test_magnitude();
        write_mode(MODE_MAG);
        send_sample(32'h0000_1234, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_sample(32'h0001_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_sample(32'hFFFF_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        send_sample(32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 1'b0);
    endtask

    task automatic test_phase();
        write_mode(MODE_PHASE);
        send_sample(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 1'b0);
        // negative real axis, both sides of the branch cut
        send_sample(32'h0000_0002, 32'hFFFF_0000, 32'h0000_0000, 1'b0);
        send_sample(32'h0000_0003, 32'hFFFF_0000, 32'hFFFF_FFFF, 1'b0);
        send_sample(32'h0000_0004, 32'h0000_0000, 32'h0001_0000, 1'b0);
        send_sample(32'h0000_0005, 32'h0000_0000, 32'hFFFF_0000, 1'b0);
        send_sample(32'h0000_0006, 32'h0001_0000, 32'h0001_0000, 1'b1);
    endtask

    task automatic test_parts();
        write_mode(MODE_IMAG);
        send_sample($urandom, $urandom, 32'h8000_0000, 1'b0);
        send_sample($urandom, $urandom, 32'h7FFF_FFFF, 1'b1);
        // unused codes fall back to real
        write_mode(MODE_SPARE5);
        send_sample($urandom, 32'h8000_0000, $urandom, 1'b0);
        write_mode(MODE_SPARE6);
        send_sample($urandom, 32'h7FFF_FFFF, $urandom, 1'b1);
        write_mode(MODE_SPARE7);
        send_sample($urandom, $urandom, $urandom, 1'b0);
    endtask

    task automatic test_polar();
        write_mode(MODE_POLAR);
        send_sample(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1);
        send_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_sample(32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    endtask

    task automatic test_random_stream(input int unsigned idle_pct, input logic [2:0] m0,
                                      input logic [2:0] m1, input logic [2:0] m2,
                                      input logic [2:0] m3);
        logic [2:0]  modes [4];
        logic [31:0] re;
        logic [31:0] im;
        modes = '{m0, m1, m2, m3};
        sender_idle_pct = idle_pct;
        foreach (modes[c])
        begin
            write_mode(modes[c]);
            for (int i = 0; i < CHUNK_ITEMS; i++)
            begin
                re = random_part();
                im = random_part();
                if ($urandom_range(19) == 0)
                begin
                    re = re | 32'h8000_0000;
                    im = $urandom_range(1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
                end
                sender_gap();
                send_sample($urandom, re, im, 1'($urandom_range(1)));
            end
        end
    endtask

    always @(posedge clk)
    begin
        polar_result_t e;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no request outstanding: %h %h %b",
                         $realtime, abscissa_out, ordinate_out, last_out);
                error_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (abscissa_out !== e.abscissa)
                begin
                    $display("%0t: abscissa_out expected %h actual %h",
                             $realtime, e.abscissa, abscissa_out);
                    error_count++;
                end
                if (ordinate_out !== e.ordinate)
                begin
                    $display("%0t: ordinate_out expected %h actual %h",
                             $realtime, e.ordinate, ordinate_out);
                    error_count++;
                end
                if (last_out !== e.last)
                begin
                    $display("%0t: last_out expected %b actual %b",
                             $realtime, e.last, last_out);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        abscissa_in     = '0;
        real_part       = '0;
        imag_part       = '0;
        last_in         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        model_mode      = MODE_REAL;
        error_count     = 0;
        cycle_count     = 0;
        sender_idle_pct = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_default_mode();
        test_magnitude();
        test_phase();
        test_parts();
        test_polar();
        test_random_stream(30, MODE_MAG, MODE_PHASE, MODE_POLAR, MODE_REAL);
        test_random_stream(88, MODE_POLAR, MODE_IMAG, MODE_SPARE7, MODE_MAG);
        test_random_stream(0, MODE_PHASE, MODE_SPARE5, MODE_POLAR, MODE_SPARE6);

        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/cps_pkg.sv
rtl/core/complex_to_polar_select.sv
rtl/core/cps_checker.sv
sim/tb_top.sv
